// ----- design/swept_tone_generator_macros.svh -----
// Assertion helpers shared by the swept tone generator.
`ifndef SWEPT_TONE_GENERATOR_MACROS_SVH
`define SWEPT_TONE_GENERATOR_MACROS_SVH

// Same-cycle implication on i_clk, checked outside reset.
`define STG_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("swept tone generator: check failed");

// Next-cycle implication on i_clk, checked outside reset.
`define STG_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("swept tone generator: check failed");

`endif

// ----- design/stg_pkg.sv -----
`timescale 1ns / 1ps

package stg_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_START_STEP = 3'd0;
    localparam logic [2:0] REG_SWEEP_SLOPE = 3'd1;
    localparam logic [2:0] REG_DURATION = 3'd2;
    localparam logic [2:0] REG_AMPLITUDE = 3'd3;
    localparam logic [2:0] REG_DECAY = 3'd4;
    localparam logic [2:0] REG_WAVEFORM = 3'd5;

    // Waveform codes; any other code selects the sine table.
    localparam logic [1:0] WAVE_SQUARE = 2'd1;
    localparam logic [1:0] WAVE_SAW = 2'd2;

    localparam int FULL_SCALE = 32000;
    localparam logic [16:0] ENV_ONE = 17'd65536;
    localparam logic [15:0] WAVE_PEAK = 16'd32767;

    // Fixed point constants for building the sine table.
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_M6,
        S_M7,
        S_M8,
        S_M9,
        S_M10,
        S_M11,
        S_DONE
    } t_state;

endpackage

// ----- design/stg_sine_rom.sv -----
`timescale 1ns / 1ps

module stg_sine_rom #(
    parameter int SINE_ENTRIES = 1024
) (
    input  logic                              i_clk,
    input  logic [$clog2(SINE_ENTRIES)-1:0]   i_addr,
    output logic signed [15:0]                o_data
);

    typedef logic signed [15:0] t_rom [SINE_ENTRIES];

    // Entry k holds round(32767 * sin(2*pi*k/SINE_ENTRIES)) from a Q30 series.
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [63:0] u;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] m;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] val;
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            u = 64'(k) * 64'd4;
            q = u / SINE_ENTRIES;
            r = u % SINE_ENTRIES;
            m = q[0] ? (64'(SINE_ENTRIES) - r) : r;
            x = (stg_pkg::HALF_PI_Q30 * m) / SINE_ENTRIES;
            x2 = (x * x) >> 30;
            t = stg_pkg::Q30_ONE;
            t = stg_pkg::Q30_ONE - ((x2 * t) >> 30) / 110;
            t = stg_pkg::Q30_ONE - ((x2 * t) >> 30) / 72;
            t = stg_pkg::Q30_ONE - ((x2 * t) >> 30) / 42;
            t = stg_pkg::Q30_ONE - ((x2 * t) >> 30) / 20;
            t = stg_pkg::Q30_ONE - ((x2 * t) >> 30) / 6;
            s = (x * t) >> 30;
            val = (s * 64'd32767 + 64'd536870912) >> 30;
            if (val > 64'd32767) begin
                val = 64'd32767;
            end
            rom[k] = (q >= 64'd2) ? -$signed(val[15:0]) : $signed(val[15:0]);
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    logic signed [15:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

// ----- design/stg_mul.sv -----
`timescale 1ns / 1ps

// Shared unsigned multiplier with a registered product.
module stg_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- design/swept_tone_generator.sv -----
`timescale 1ns / 1ps

// Channel   Direction  tdata                  tuser
// s_axis    in         [15:0] prior_sample    [0] start_req
// m_axis    out        [15:0] mixed_sample    [0] active
// cfg       in         i_cfg_index selects the register, i_cfg_data its value
//
// A frame goes from S_CHECK through S_M1 to S_M11 into S_DONE, or straight to S_DONE
// once past the duration: the sequencer walks eleven steps through the one shared
// 32x32 multiplier and the sine ROM. S_DONE loads the output register and returns to
// S_IDLE, where the next word is taken; s_axis_tready is high only while idle. The
// result waits in the output register; a stalled m_axis holds the last step until
// the register is free. Reset is synchronous, active low.
`include "swept_tone_generator_macros.svh"

module swept_tone_generator #(
    parameter int SINE_ENTRIES = 1024,
    parameter int ATTACK_FRAMES = 128,
    parameter int PHASE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] prior_sample
    input  logic [0:0]  s_axis_tuser,  // [0] start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [15:0] mixed_sample
    output logic [0:0]  m_axis_tuser,  // [0] active
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int KW = $clog2(SINE_ENTRIES);
    localparam int SH = 48 - PHASE_BITS;
    localparam int KSH = PHASE_BITS - 16;
    localparam logic [31:0] N32 = 32'(SINE_ENTRIES);
    localparam logic [31:0] A32 = 32'(ATTACK_FRAMES);
    localparam logic [32:0] RECIP_FULL = 33'(64'd2147483648 / ATTACK_FRAMES);
    localparam logic [31:0] RECIP = RECIP_FULL[31:0];

    // Configuration.
    logic [31:0] r_start_step;
    logic [31:0] r_slope;
    logic [15:0] r_dur;
    logic [14:0] r_amp;
    logic [15:0] r_decay;
    logic [1:0]  r_wave;

    // Tone state.
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] r_step;
    logic [16:0]           r_env;
    logic [15:0]           r_fi;

    stg_pkg::t_state r_state;
    stg_pkg::t_state n_state;

    logic [KW-1:0]      r_k;
    logic               r_pass;
    logic               r_neg;
    logic signed [15:0] r_prior;
    logic [63:0]        r_acc;
    logic [31:0]        r_envfs;
    logic [15:0]        r_tone;
    logic [31:0]        r_x;
    logic [31:0]        r_q;
    logic [15:0]        r_res;
    logic               r_ovalid;
    logic [15:0]        r_odata;
    logic               r_oactive;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        prod;
    logic signed [15:0] rom_data;
    logic               out_free;

    stg_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    stg_sine_rom #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (r_k),
        .o_data (rom_data)
    );

    // Register values rescaled to phase units through a 16-bit fractional extension.
    logic signed [79:0]    slope_wide;
    logic signed [79:0]    slope_shift;
    logic [79:0]           start_wide;
    logic [PHASE_BITS-1:0] slope_units;
    logic [PHASE_BITS-1:0] start_units;
    logic [47:0]           phase_ext;

    assign slope_wide = {{32{r_slope[31]}}, r_slope, 16'b0};
    assign slope_shift = slope_wide >>> SH;
    assign slope_units = slope_shift[PHASE_BITS-1:0];
    assign start_wide = {32'b0, r_start_step, 16'b0} >> SH;
    assign start_units = start_wide[PHASE_BITS-1:0];
    assign phase_ext = 48'(r_phase);

    // Wave selection from the phase or the table.
    logic [15:0] wave_mag;
    logic        wave_neg;
    logic [15:0] saw_top;

    assign saw_top = r_phase[PHASE_BITS-1 -: 16];

    always_comb begin
        case (r_wave)
            stg_pkg::WAVE_SQUARE: begin
                wave_neg = r_phase[PHASE_BITS-1];
                wave_mag = stg_pkg::WAVE_PEAK;
            end
            stg_pkg::WAVE_SAW: begin
                wave_neg = saw_top[15];
                wave_mag = saw_top[15] ? (16'd0 - saw_top) : saw_top;
            end
            default: begin
                wave_neg = rom_data[15];
                wave_mag = rom_data[15] ? (16'd0 - rom_data) : rom_data;
            end
        endcase
    end

    // Final mix: attack quotient correction, sign and saturation.
    logic [31:0]        rem;
    logic [31:0]        q_fix;
    logic               in_attack;
    logic [15:0]        tone_sel;
    logic signed [17:0] sum;
    logic [15:0]        sat;
    logic [63:0]        k_sum;
    logic [63:0]        k_shift;
    logic [63:0]        tone_round;

    assign rem = r_x - prod[31:0];
    assign q_fix = (rem >= A32) ? (r_q + 32'd1) : r_q;
    assign in_attack = {16'b0, r_fi} < A32;
    assign tone_sel = in_attack ? q_fix[15:0] : r_tone;
    assign sum = $signed({{2{r_prior[15]}}, r_prior})
               + (r_neg ? -$signed({2'b0, tone_sel}) : $signed({2'b0, tone_sel}));
    assign k_sum = prod + r_acc;
    assign k_shift = k_sum >> KSH;
    assign tone_round = prod + 64'h0000_2000_0000_0000;

    always_comb begin
        if (sum > $signed(18'(stg_pkg::FULL_SCALE))) begin
            sat = 16'(stg_pkg::FULL_SCALE);
        end else if (sum < $signed(18'(-stg_pkg::FULL_SCALE))) begin
            sat = 16'(-stg_pkg::FULL_SCALE);
        end else begin
            sat = sum[15:0];
        end
    end

    assign out_free = !r_ovalid || m_axis_tready;

    // Sequencer: next state, handshake and multiplier operands.
    always_comb begin
        n_state = r_state;
        s_axis_tready = 1'b0;
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            stg_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = stg_pkg::S_CHECK;
                end
            end
            stg_pkg::S_CHECK: begin
                n_state = (r_fi > r_dur) ? stg_pkg::S_DONE : stg_pkg::S_M1;
            end
            stg_pkg::S_M1: begin
                mul_a = {16'b0, phase_ext[15:0]};
                mul_b = N32;
                n_state = stg_pkg::S_M2;
            end
            stg_pkg::S_M2: begin
                mul_a = phase_ext[47:16];
                mul_b = N32;
                n_state = stg_pkg::S_M3;
            end
            stg_pkg::S_M3: begin
                mul_a = {15'b0, r_env};
                mul_b = 32'(stg_pkg::FULL_SCALE);
                n_state = stg_pkg::S_M4;
            end
            stg_pkg::S_M4: begin
                mul_a = {15'b0, r_env};
                mul_b = {16'b0, r_decay};
                n_state = stg_pkg::S_M5;
            end
            stg_pkg::S_M5: begin
                mul_a = {16'b0, wave_mag};
                mul_b = {17'b0, r_amp};
                n_state = stg_pkg::S_M6;
            end
            stg_pkg::S_M6: begin
                mul_a = prod[31:0];
                mul_b = r_envfs;
                n_state = stg_pkg::S_M7;
            end
            stg_pkg::S_M7: begin
                n_state = stg_pkg::S_M8;
            end
            stg_pkg::S_M8: begin
                mul_a = {16'b0, r_tone};
                mul_b = {16'b0, r_fi};
                n_state = stg_pkg::S_M9;
            end
            stg_pkg::S_M9: begin
                mul_a = prod[31:0];
                mul_b = RECIP;
                n_state = stg_pkg::S_M10;
            end
            stg_pkg::S_M10: begin
                mul_a = prod[62:31];
                mul_b = A32;
                n_state = stg_pkg::S_M11;
            end
            stg_pkg::S_M11: begin
                n_state = stg_pkg::S_DONE;
            end
            stg_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = stg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration, tone state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_step <= 32'd0;
            r_slope <= 32'd0;
            r_dur <= 16'd0;
            r_amp <= 15'd0;
            r_decay <= 16'hFFFF;
            r_wave <= 2'd0;
            r_phase <= '0;
            r_step <= '0;
            r_env <= stg_pkg::ENV_ONE;
            r_fi <= 16'd0;
            r_k <= '0;
            r_pass <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    stg_pkg::REG_START_STEP: r_start_step <= i_cfg_data;
                    stg_pkg::REG_SWEEP_SLOPE: r_slope <= i_cfg_data;
                    stg_pkg::REG_DURATION: r_dur <= i_cfg_data[15:0];
                    stg_pkg::REG_AMPLITUDE: r_amp <= i_cfg_data[14:0];
                    stg_pkg::REG_DECAY: r_decay <= i_cfg_data[15:0];
                    stg_pkg::REG_WAVEFORM: r_wave <= i_cfg_data[1:0];
                    default: begin
                    end
                endcase
            end

            if (r_state == stg_pkg::S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                stg_pkg::S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tuser[0]) begin
                        r_phase <= '0;
                        r_step <= start_units;
                        r_env <= stg_pkg::ENV_ONE;
                        r_fi <= 16'd0;
                    end
                end
                stg_pkg::S_CHECK: begin
                    r_pass <= r_fi > r_dur;
                    if (r_fi <= r_dur) begin
                        r_phase <= r_phase + r_step;
                    end
                end
                stg_pkg::S_M3: begin
                    r_k <= k_shift[KW-1:0];
                end
                stg_pkg::S_M5: begin
                    r_env <= prod[32:16];
                end
                stg_pkg::S_DONE: begin
                    if (out_free) begin
                        if (!r_pass) begin
                            r_step <= r_step + slope_units;
                            if (r_fi != 16'hFFFF) begin
                                r_fi <= r_fi + 16'd1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath words.
    always_ff @(posedge i_clk) begin
        case (r_state)
            stg_pkg::S_IDLE: begin
                r_prior <= s_axis_tdata;
            end
            stg_pkg::S_M2: begin
                r_acc <= prod >> 16;
            end
            stg_pkg::S_M4: begin
                r_envfs <= prod[31:0];
            end
            stg_pkg::S_M5: begin
                r_neg <= wave_neg;
            end
            stg_pkg::S_M7: begin
                r_tone <= tone_round[61:46];
            end
            stg_pkg::S_M9: begin
                r_x <= prod[31:0];
            end
            stg_pkg::S_M10: begin
                r_q <= prod[62:31];
            end
            stg_pkg::S_M11: begin
                r_res <= sat;
            end
            stg_pkg::S_DONE: begin
                if (out_free) begin
                    r_odata <= r_pass ? r_prior : r_res;
                    r_oactive <= !r_pass;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_oactive;

    logic in_fire;
    logic out_in_range;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_in_range = ($signed(m_axis_tdata) <= 16'sd32000)
                        && ($signed(m_axis_tdata) >= -16'sd32000);

    `STG_ASSERT_IMP(a_sine_addr, r_state == stg_pkg::S_M4, 32'(r_k) < N32)
    `STG_ASSERT_IMP(a_env_bound, 1'b1, r_env <= stg_pkg::ENV_ONE)
    `STG_ASSERT_NXT(a_restart, in_fire && s_axis_tuser[0], r_fi == 16'd0 && r_phase == '0)
    `STG_ASSERT_IMP(a_out_load, $rose(r_ovalid), $past(r_state) == stg_pkg::S_DONE)
    `STG_ASSERT_IMP(a_active_range, m_axis_tvalid && m_axis_tuser[0], out_in_range)

endmodule
